/* hdl/btlv_pkg.sv */
// ----------------------------------------------------------------------------
// btlv_pkg: shared types and constants for the ber-tlv stream parser
// result codes, request codes, result record and parser-to-queue bundle
// ----------------------------------------------------------------------------
package btlv_pkg;

  // field widths fixed by the interface
  localparam int unsigned TAG_W   = 32;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 3;

  // parameter defaults
  localparam int unsigned LENGTH_BITS_DEF    = 32;
  localparam int unsigned MAX_TAG_OCTETS_DEF = 4;

  // result queue depth, room for two results per request is needed
  localparam int unsigned QUEUE_DEPTH = 4;

  // request selector carried in tuser
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ABSORB  = 3'd0,
    KIND_HEADER  = 3'd1,
    KIND_VALUE   = 3'd2,
    KIND_INVALID = 3'd3,
    KIND_END     = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [TAG_W-1:0]   tag_value;
    logic [LEN_W-1:0]   val_len;
    logic [LEN_W-1:0]   enc_len;
    logic [BYTE_W-1:0]  value_byte;
    logic               last;
  } result_t;

  // up to two results caused by one request
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t res0;
    result_t res1;
  } parse_out_t;

endpackage

/* hdl/btlv_parse.sv */
// ----------------------------------------------------------------------------
// btlv_parse: parser state and combinational step logic
// consumes one request per cycle and produces zero, one or two results
// ----------------------------------------------------------------------------
module btlv_parse #(
  parameter int unsigned LENGTH_BITS    = btlv_pkg::LENGTH_BITS_DEF,
  parameter int unsigned MAX_TAG_OCTETS = btlv_pkg::MAX_TAG_OCTETS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         op,
  input  logic [btlv_pkg::BYTE_W-1:0]  data_byte,
  input  logic [btlv_pkg::LEN_W-1:0]   buffer_length,
  output btlv_pkg::parse_out_t         out
);

  localparam int unsigned LB    = LENGTH_BITS;
  localparam int unsigned CMP_W = (LB > btlv_pkg::LEN_W) ? LB : btlv_pkg::LEN_W;
  localparam int unsigned MAX_LEN_OCTETS = LB / 8;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TAG_FIRST = 3'd1,
    PH_TAG_MORE  = 3'd2,
    PH_LEN_FIRST = 3'd3,
    PH_LEN_MORE  = 3'd4,
    PH_VALUE     = 3'd5,
    PH_ERROR     = 3'd6,
    PH_DONE      = 3'd7
  } phase_t;

  phase_t                        phase, phase_next;
  logic [btlv_pkg::TAG_W-1:0]    tag_acc, tag_acc_next;
  logic [2:0]                    tag_cnt, tag_cnt_next;
  logic [LB-1:0]                 len_acc, len_acc_next;
  logic [3:0]                    len_left, len_left_next;
  logic [3:0]                    hdr_cnt, hdr_cnt_next;
  logic [btlv_pkg::LEN_W-1:0]    buf_left, buf_left_next;
  logic [btlv_pkg::LEN_W-1:0]    val_left, val_left_next;

  logic                          fail;
  logic                          hdone;
  logic [LB-1:0]                 hvlen;
  logic [btlv_pkg::LEN_W-1:0]    vlen32;
  logic [btlv_pkg::LEN_W-1:0]    bl;
  logic [btlv_pkg::LEN_W-1:0]    vl;
  logic [6:0]                    lol;
  logic [LB-1:0]                 len_shift;
  logic                          active;

  always_comb begin
    phase_next    = phase;
    tag_acc_next  = tag_acc;
    tag_cnt_next  = tag_cnt;
    len_acc_next  = len_acc;
    len_left_next = len_left;
    hdr_cnt_next  = hdr_cnt;
    buf_left_next = buf_left;
    val_left_next = val_left;
    out           = '0;
    fail          = 1'b0;
    hdone         = 1'b0;
    hvlen         = '0;
    vlen32        = '0;
    bl            = buf_left - 32'd1;
    vl            = val_left;
    lol           = data_byte[6:0];
    len_shift     = LB'({len_acc, data_byte});

    case (phase)
      PH_TAG_FIRST, PH_TAG_MORE, PH_LEN_FIRST, PH_LEN_MORE, PH_VALUE: active = 1'b1;
      default: active = 1'b0;
    endcase

    if (in_valid) begin
      if (op == btlv_pkg::OP_BEGIN) begin
        buf_left_next = buffer_length;
        if (buffer_length == '0) begin
          phase_next    = PH_DONE;
          out.valid0    = 1'b1;
          out.res0.kind = btlv_pkg::KIND_END;
        end else begin
          phase_next = PH_TAG_FIRST;
        end
      end else if (active) begin
        if (buf_left == '0) begin
          fail = 1'b1;
        end else begin
          buf_left_next = bl;
          case (phase)
            PH_TAG_FIRST: begin
              tag_acc_next = btlv_pkg::TAG_W'(data_byte);
              tag_cnt_next = 3'd1;
              hdr_cnt_next = 4'd1;
              if (data_byte[4:0] == 5'h1f) begin
                if (bl == '0 || 3'd1 >= 3'(MAX_TAG_OCTETS)) fail = 1'b1;
                else phase_next = PH_TAG_MORE;
              end else begin
                if (bl == '0) fail = 1'b1;
                else phase_next = PH_LEN_FIRST;
              end
              out.valid0    = 1'b1;
              out.res0.kind = btlv_pkg::KIND_ABSORB;
            end
            PH_TAG_MORE: begin
              if (tag_cnt == 3'd1 && data_byte[6:0] == 7'd0) begin
                fail = 1'b1;
              end else begin
                tag_acc_next = {tag_acc[btlv_pkg::TAG_W-9:0], data_byte};
                tag_cnt_next = tag_cnt + 3'd1;
                hdr_cnt_next = hdr_cnt + 4'd1;
                if (data_byte[7]) begin
                  if (bl == '0 || tag_cnt_next >= 3'(MAX_TAG_OCTETS)) fail = 1'b1;
                end else begin
                  if (bl == '0) fail = 1'b1;
                  else phase_next = PH_LEN_FIRST;
                end
                out.valid0    = 1'b1;
                out.res0.kind = btlv_pkg::KIND_ABSORB;
              end
            end
            PH_LEN_FIRST: begin
              hdr_cnt_next = hdr_cnt + 4'd1;
              if (!data_byte[7]) begin
                hdone = 1'b1;
                hvlen = LB'(data_byte);
              end else if (lol == 7'd0 || lol > 7'(MAX_LEN_OCTETS) ||
                           btlv_pkg::LEN_W'(lol) > bl) begin
                fail = 1'b1;
              end else begin
                len_left_next = lol[3:0];
                len_acc_next  = '0;
                phase_next    = PH_LEN_MORE;
                out.valid0    = 1'b1;
                out.res0.kind = btlv_pkg::KIND_ABSORB;
              end
            end
            PH_LEN_MORE: begin
              hdr_cnt_next = hdr_cnt + 4'd1;
              if (len_acc == '0 && data_byte == 8'd0) begin
                fail = 1'b1;
              end else if ((len_acc >> (LB - 8)) != '0) begin
                // next octet would overflow the length register
                fail = 1'b1;
              end else begin
                len_acc_next  = len_shift;
                len_left_next = len_left - 4'd1;
                if (len_left_next != 4'd0) begin
                  out.valid0    = 1'b1;
                  out.res0.kind = btlv_pkg::KIND_ABSORB;
                end else if (len_shift < LB'(128)) begin
                  // long form must not encode a short-form value
                  fail = 1'b1;
                end else begin
                  hdone = 1'b1;
                  hvlen = len_shift;
                end
              end
            end
            default: begin
              out.valid0          = 1'b1;
              out.res0.kind       = btlv_pkg::KIND_VALUE;
              out.res0.value_byte = data_byte;
              if (val_left != '0) vl = val_left - 32'd1;
              val_left_next = vl;
              if (vl == '0) begin
                if (bl == '0) begin
                  phase_next    = PH_DONE;
                  out.valid1    = 1'b1;
                  out.res1.kind = btlv_pkg::KIND_END;
                end else begin
                  phase_next = PH_TAG_FIRST;
                end
              end
            end
          endcase
        end
      end
    end

    // element header complete
    if (hdone) begin
      if (CMP_W'(hvlen) > CMP_W'(bl)) begin
        fail = 1'b1;
      end else begin
        vlen32             = btlv_pkg::LEN_W'(hvlen);
        out.valid0         = 1'b1;
        out.res0.kind      = btlv_pkg::KIND_HEADER;
        out.res0.tag_value = tag_acc_next;
        out.res0.val_len   = vlen32;
        out.res0.enc_len   = btlv_pkg::LEN_W'(hdr_cnt_next) + vlen32;
        val_left_next      = vlen32;
        if (hvlen != '0) begin
          phase_next = PH_VALUE;
        end else if (bl == '0) begin
          phase_next    = PH_DONE;
          out.valid1    = 1'b1;
          out.res1.kind = btlv_pkg::KIND_END;
        end else begin
          phase_next = PH_TAG_FIRST;
        end
      end
    end

    if (fail) begin
      phase_next    = PH_ERROR;
      out.valid0    = 1'b1;
      out.valid1    = 1'b0;
      out.res0      = '0;
      out.res1      = '0;
      out.res0.kind = btlv_pkg::KIND_INVALID;
    end

    if (out.valid1) out.res1.last = 1'b1;
    else if (out.valid0) out.res0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      tag_acc  <= '0;
      tag_cnt  <= '0;
      len_acc  <= '0;
      len_left <= '0;
      hdr_cnt  <= '0;
      buf_left <= '0;
      val_left <= '0;
    end else begin
      phase    <= phase_next;
      tag_acc  <= tag_acc_next;
      tag_cnt  <= tag_cnt_next;
      len_acc  <= len_acc_next;
      len_left <= len_left_next;
      hdr_cnt  <= hdr_cnt_next;
      buf_left <= buf_left_next;
      val_left <= val_left_next;
    end
  end

endmodule

/* hdl/btlv_result_queue.sv */
// ----------------------------------------------------------------------------
// btlv_result_queue: small result queue between parser and output stream
// takes up to two results per cycle, hands one per out_ready cycle downstream
// ----------------------------------------------------------------------------
module btlv_result_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  btlv_pkg::parse_out_t  in,
  output logic                  has_room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output btlv_pkg::result_t     out_res
);

  localparam int unsigned DEPTH = btlv_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  btlv_pkg::result_t   entries [DEPTH];
  logic [PTR_W-1:0]    wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]    rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]    count, count_next;
  logic                pop;
  logic [PTR_W-1:0]    wr_ptr1;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_res   = entries[rd_ptr];
  assign has_room  = (count <= CNT_W'(DEPTH - 2));
  assign wr_ptr1   = wr_ptr + PTR_W'(1);

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (in.valid0) begin
      wr_ptr_next = wr_ptr1;
      count_next  = count_next + CNT_W'(1);
    end
    if (in.valid1) begin
      wr_ptr_next = wr_ptr + PTR_W'(2);
      count_next  = count_next + CNT_W'(1);
    end
    if (pop) begin
      rd_ptr_next = rd_ptr + PTR_W'(1);
      count_next  = count_next - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid0) entries[wr_ptr] <= in.res0;
    if (in.valid1) entries[wr_ptr1] <= in.res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

/* hdl/ber_tlv_stream_parser.sv */
// ----------------------------------------------------------------------------
// ber_tlv_stream_parser: streaming der-strict ber-tlv element parser
// begin requests load the buffer length, byte requests are parsed one a cycle
// ----------------------------------------------------------------------------
// results are registered in the result queue, which drives m_tvalid
// throughput: one request per cycle; the parser state updates in one step
//   and its results go to a four-entry result queue; s_tready is low while
//   the queue holds more than two results (a request may cause two)
// reset: rst (synchronous, active high) returns the parser to idle,
//   waiting for a begin request, and empties the result queue
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser #(
  parameter int unsigned LENGTH_BITS    = btlv_pkg::LENGTH_BITS_DEF,
  parameter int unsigned MAX_TAG_OCTETS = btlv_pkg::MAX_TAG_OCTETS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  // request stream
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [39:0]   s_tdata,   // data_byte[7:0], buffer_length[39:8]
  input  logic          s_tuser,   // op: 0 begin, 1 data byte
  // result stream
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata,   // tag_value[31:0], value len[63:32],
                                   // header plus value len[95:64],
                                   // value_byte[103:96]
  output logic [2:0]    m_tuser,   // kind
  output logic          m_tlast    // last result of its request
);

  // request accepted this cycle
  logic                  req_take;
  // results of the accepted request
  btlv_pkg::parse_out_t  step_out;
  // head of the result queue
  btlv_pkg::result_t     head;
  logic                  room;

  assign s_tready = room;
  assign req_take = s_tvalid && s_tready;

  // tag, length and value tracking, one step per request
  btlv_parse #(
    .LENGTH_BITS    (LENGTH_BITS),
    .MAX_TAG_OCTETS (MAX_TAG_OCTETS)
  ) u_parse (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (req_take),
    .op            (s_tuser),
    .data_byte     (s_tdata[7:0]),
    .buffer_length (s_tdata[39:8]),
    .out           (step_out)
  );

  // result buffering decouples the parser from output stalls
  btlv_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in        (step_out),
    .has_room  (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (head)
  );

  // pack the result fields, fields not used by a kind are zero
  assign m_tdata = {head.value_byte, head.enc_len,
                    head.val_len, head.tag_value};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

/* bench/ber_tlv_stream_parser_tb.sv */
// ----------------------------------------------------------------------------
// ber_tlv_stream_parser_tb: self-checking bench for the ber-tlv stream parser
// drives begin and byte requests (directed, well-formed, malformed, noise),
// predicts every result from its own parser model and compares in order
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PARSE_LEN_BITS = btlv_pkg::LENGTH_BITS_DEF;
  localparam int unsigned TAG_LEN_MAX    = btlv_pkg::MAX_TAG_OCTETS_DEF;
  localparam logic [63:0] LEN_LIMIT      = {64{1'b1}} >> (64 - PARSE_LEN_BITS);
  localparam logic [4:0]  HIGH_TAG_MARK  = 5'h1f;
  localparam int          QUIET_LIMIT    = 2000;
  localparam int          HOLD_CYCLES    = 300;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TAG_FIRST, ST_TAG_MORE, ST_LEN_FIRST,
    ST_LEN_MORE, ST_VALUE, ST_ERROR, ST_DONE
  } parse_phase_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [39:0]  s_tdata = '0;   // data_byte[7:0], buffer_length[39:8]
  logic         s_tuser = 1'b0; // op
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;        // tag, value length, encoded length, value byte
  logic [2:0]   m_tuser;        // kind
  logic         m_tlast;

  // predicted parser state
  parse_phase_t phase = ST_IDLE;
  logic [31:0]  tag_acc = '0;
  int           tag_count = 0;
  logic [63:0]  len_acc = '0;
  int           len_octets_left = 0;
  logic [3:0]   hdr_bytes = '0;
  logic [31:0]  buf_left = '0;
  logic [31:0]  val_left = '0;

  btlv_pkg::result_t step_results[$];
  btlv_pkg::result_t expected_results[$];
  logic [7:0]        tlv_bytes[$];

  bit           idle_on = 1'b1;
  int           rx_hold_left = 0;
  int           items_sent = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;

  always #5 clk = ~clk;

  ber_tlv_stream_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // --------------------------------------------------------------------------
  // parser prediction
  // --------------------------------------------------------------------------
  function automatic btlv_pkg::result_t make_result(btlv_pkg::kind_t k,
                                                    logic [31:0] tag = '0,
                                                    logic [31:0] vlen = '0,
                                                    logic [31:0] elen = '0,
                                                    logic [7:0] vb = '0);
    btlv_pkg::result_t r;
    r.kind       = k;
    r.tag_value  = tag;
    r.val_len    = vlen;
    r.enc_len    = elen;
    r.value_byte = vb;
    r.last       = 1'b0;
    return r;
  endfunction

  // any error parks the parser until the next begin
  function automatic void flag_invalid();
    phase = ST_ERROR;
    step_results.push_back(make_result(btlv_pkg::KIND_INVALID));
  endfunction

  // header complete: value must fit in what is left of the buffer
  function automatic void close_header(logic [63:0] vlen);
    if (vlen > {32'b0, buf_left}) begin
      flag_invalid();
    end else begin
      step_results.push_back(make_result(btlv_pkg::KIND_HEADER, tag_acc, vlen[31:0],
                                         32'(hdr_bytes) + vlen[31:0]));
      val_left = vlen[31:0];
      if (vlen != 0) begin
        phase = ST_VALUE;
      end else if (buf_left == 0) begin
        // empty value closing the buffer
        phase = ST_DONE;
        step_results.push_back(make_result(btlv_pkg::KIND_END));
      end else begin
        phase = ST_TAG_FIRST;
      end
    end
  endfunction

  function automatic void predict_parse(logic op, logic [7:0] b, logic [31:0] blen);
    btlv_pkg::result_t tail;
    step_results.delete();
    if (op == btlv_pkg::OP_BEGIN) begin
      // begin always restarts, whatever was in flight
      tag_acc         = '0;
      tag_count       = 0;
      len_acc         = '0;
      len_octets_left = 0;
      hdr_bytes       = '0;
      val_left        = '0;
      buf_left        = blen;
      if (blen == 0) begin
        phase = ST_DONE;
        step_results.push_back(make_result(btlv_pkg::KIND_END));
      end else begin
        phase = ST_TAG_FIRST;
      end
    end else if (phase >= ST_TAG_FIRST && phase <= ST_VALUE) begin
      if (buf_left == 0) begin
        flag_invalid();
      end else begin
        buf_left = buf_left - 1;
        case (phase)
          ST_TAG_FIRST: begin
            tag_acc   = {24'b0, b};
            tag_count = 1;
            hdr_bytes = 4'd1;
            if (b[4:0] == HIGH_TAG_MARK) begin
              if (buf_left == 0 || tag_count >= TAG_LEN_MAX) begin
                flag_invalid();
              end else begin
                phase = ST_TAG_MORE;
                step_results.push_back(make_result(btlv_pkg::KIND_ABSORB));
              end
            end else if (buf_left == 0) begin
              flag_invalid();
            end else begin
              phase = ST_LEN_FIRST;
              step_results.push_back(make_result(btlv_pkg::KIND_ABSORB));
            end
          end
          ST_TAG_MORE: begin
            // first subsequent group may not be zero
            if (tag_count == 1 && b[6:0] == 7'd0) begin
              flag_invalid();
            end else begin
              tag_acc   = {tag_acc[23:0], b};
              tag_count = tag_count + 1;
              hdr_bytes = hdr_bytes + 4'd1;
              if (b[7]) begin
                if (buf_left == 0 || tag_count >= TAG_LEN_MAX) begin
                  flag_invalid();
                end else begin
                  step_results.push_back(make_result(btlv_pkg::KIND_ABSORB));
                end
              end else if (buf_left == 0) begin
                flag_invalid();
              end else begin
                phase = ST_LEN_FIRST;
                step_results.push_back(make_result(btlv_pkg::KIND_ABSORB));
              end
            end
          end
          ST_LEN_FIRST: begin
            hdr_bytes = hdr_bytes + 4'd1;
            if (!b[7]) begin
              close_header({56'b0, b});
            end else begin
              len_octets_left = int'(b[6:0]);
              if (len_octets_left == 0 || len_octets_left > PARSE_LEN_BITS / 8 ||
                  32'(len_octets_left) > buf_left) begin
                flag_invalid();
              end else begin
                len_acc = '0;
                phase   = ST_LEN_MORE;
                step_results.push_back(make_result(btlv_pkg::KIND_ABSORB));
              end
            end
          end
          ST_LEN_MORE: begin
            hdr_bytes = hdr_bytes + 4'd1;
            if (len_acc == 0 && b == 8'd0) begin
              flag_invalid();
            end else if (len_acc > (LEN_LIMIT >> 8)) begin
              flag_invalid();
            end else begin
              len_acc         = ((len_acc << 8) | {56'b0, b}) & LEN_LIMIT;
              len_octets_left = len_octets_left - 1;
              if (len_octets_left != 0) begin
                step_results.push_back(make_result(btlv_pkg::KIND_ABSORB));
              end else if (len_acc < 128) begin
                flag_invalid();
              end else begin
                close_header(len_acc);
              end
            end
          end
          ST_VALUE: begin
            step_results.push_back(make_result(btlv_pkg::KIND_VALUE, '0, '0, '0, b));
            if (val_left != 0) val_left = val_left - 1;
            if (val_left == 0) begin
              if (buf_left == 0) begin
                phase = ST_DONE;
                step_results.push_back(make_result(btlv_pkg::KIND_END));
              end else begin
                phase = ST_TAG_FIRST;
              end
            end
          end
          default: ;
        endcase
      end
    end
    if (step_results.size() != 0) begin
      tail      = step_results.pop_back();
      tail.last = 1'b1;
      step_results.push_back(tail);
    end
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(btlv_pkg::result_t got, btlv_pkg::result_t want,
                                 bit orphan);
    mismatches++;
    if (mismatches <= 10) begin
      if (orphan)
        $display("unexpected result: kind %0d tag %h vlen %h elen %h byte %h last %b",
                 got.kind, got.tag_value, got.val_len, got.enc_len,
                 got.value_byte, got.last);
      else
        $display("mismatch: expected kind %0d tag %h vlen %h elen %h byte %h last %b",
                 want.kind, want.tag_value, want.val_len, want.enc_len,
                 want.value_byte, want.last,
                 "\n          got      kind %0d tag %h vlen %h elen %h byte %h last %b",
                 got.kind, got.tag_value, got.val_len, got.enc_len,
                 got.value_byte, got.last);
    end
  endtask

  // results are compared before the request of the same edge is predicted
  always @(posedge clk) begin
    btlv_pkg::result_t got;
    btlv_pkg::result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.kind       = btlv_pkg::kind_t'(m_tuser);
        got.tag_value  = m_tdata[31:0];
        got.val_len    = m_tdata[63:32];
        got.enc_len    = m_tdata[95:64];
        got.value_byte = m_tdata[103:96];
        got.last       = m_tlast;
        if (expected_results.size() == 0) begin
          report_mismatch(got, got, 1'b1);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.tag_value !== want.tag_value ||
              got.val_len !== want.val_len ||
              got.enc_len !== want.enc_len ||
              got.value_byte !== want.value_byte || got.last !== want.last)
            report_mismatch(got, want, 1'b0);
        end
      end
      if (s_tvalid && s_tready)
        predict_parse(s_tuser, s_tdata[7:0], s_tdata[39:8]);
    end
  end

  // watchdog: too long without any request or result moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles < QUIET_LIMIT) begin
      quiet_cycles++;
    end else begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold when asked for
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      m_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      m_tready <= !(idle_on && $urandom_range(99) < 33);
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------
  task automatic send_request(logic op, logic [7:0] data_b, logic [31:0] blen);
    int gap;
    if (idle_on && $urandom_range(99) < 33) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {blen, data_b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // begin with the given length, then the first count bytes of tlv_bytes
  task automatic send_buffer(logic [31:0] blen, int count);
    int i;
    send_request(btlv_pkg::OP_BEGIN, 8'($urandom), blen);
    for (i = 0; i < count && i < tlv_bytes.size(); i++)
      send_request(btlv_pkg::OP_BYTE, tlv_bytes[i], $urandom);
  endtask

  task automatic send_noise(int n);
    repeat (n) send_request(btlv_pkg::OP_BYTE, 8'($urandom), $urandom);
  endtask

  // append one well-formed element with random tag form and content
  function automatic void add_element(int vmax);
    int         n_tag;
    int         vlen;
    int         i;
    logic [7:0] b;
    n_tag = ($urandom_range(99) < 50) ? 1 : $urandom_range(2, TAG_LEN_MAX);
    b = 8'($urandom);
    if (n_tag == 1) begin
      if (b[4:0] == HIGH_TAG_MARK) b[0] = 1'b0;
      tlv_bytes.push_back(b);
    end else begin
      b[4:0] = HIGH_TAG_MARK;
      tlv_bytes.push_back(b);
      for (i = 1; i < n_tag; i++) begin
        b    = 8'($urandom);
        b[7] = (i != n_tag - 1);
        if (i == 1 && b[6:0] == 7'd0) b[0] = 1'b1;
        tlv_bytes.push_back(b);
      end
    end
    if ($urandom_range(99) < 3) begin
      // long form, kept short enough to stream the value
      vlen = $urandom_range(128, 300);
      if (vlen < 256) begin
        tlv_bytes.push_back(8'h81);
      end else begin
        tlv_bytes.push_back(8'h82);
        tlv_bytes.push_back(vlen[15:8]);
      end
      tlv_bytes.push_back(vlen[7:0]);
    end else begin
      vlen = $urandom_range(0, vmax);
      tlv_bytes.push_back(vlen[7:0]);
    end
    repeat (vlen) begin
      b = 8'($urandom);
      tlv_bytes.push_back(b);
    end
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    send_request(btlv_pkg::OP_BYTE, 8'h5a, '1);   // byte before any begin
    send_request(btlv_pkg::OP_BEGIN, 8'hff, '0);  // empty buffer ends at once
    send_request(btlv_pkg::OP_BYTE, 8'h00, '0);   // byte after end
    tlv_bytes = '{8'h04, 8'h01, 8'hab}; // element fills the buffer exactly
    send_buffer(3, 3);
    tlv_bytes = '{8'h05, 8'h00};        // empty value closing the buffer
    send_buffer(2, 2);
    tlv_bytes = '{8'h1f, 8'h80, 8'hff}; // zero first tag group, then refused byte
    send_buffer(3, 3);
    // four-octet tag, four-octet length near the top of the range
    tlv_bytes = '{8'h9f, 8'hff, 8'hff, 8'h7f, 8'h84,
                  8'hff, 8'hff, 8'hff, 8'hf0, 8'h00};
    send_buffer('1, 10);
  endtask

  task automatic test_wellformed(int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      tlv_bytes.delete();
      repeat ($urandom_range(1, 4)) add_element(20);
      send_buffer(tlv_bytes.size(), tlv_bytes.size());
    end
  endtask

  task automatic test_full_rate(int target);
    idle_on = 1'b0;
    test_wellformed(target);
    idle_on = 1'b1;
  endtask

  // result side held off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    idle_on      = 1'b0;
    rx_hold_left = HOLD_CYCLES;
    tlv_bytes.delete();
    repeat (3) add_element(20);
    send_buffer(tlv_bytes.size(), tlv_bytes.size());
    idle_on = 1'b1;
  endtask

  task automatic test_malformed(int target);
    int         start;
    int         size;
    int         i;
    logic [7:0] bad[$];
    start = items_sent;
    while (items_sent - start < target) begin
      tlv_bytes.delete();
      repeat ($urandom_range(1, 3)) add_element(12);
      size = tlv_bytes.size();
      case ($urandom_range(0, 7))
        0: send_buffer($urandom_range(0, size - 1), size);   // buffer too short
        1: send_buffer(size + $urandom_range(1, 5), size);   // buffer longer than data
        2: begin
          tlv_bytes[$urandom_range(0, size - 1)] = 8'($urandom);
          send_buffer(size, size);
        end
        3: begin
          case ($urandom_range(0, 7))
            0: bad = '{8'h1f, 8'h80};                         // zero first tag group
            1: bad = '{8'h1f, 8'h81, 8'h82, 8'h83, 8'h84};    // tag too long
            2: bad = '{8'h04, 8'h82, 8'h00, 8'h85};           // length leading zero
            3: bad = '{8'h04, 8'h81, 8'h05};                  // long form below 128
            4: bad = '{8'h04, 8'h80};                         // no length octets
            5: bad = '{8'h04, 8'h85, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01};
            6: bad = '{8'h04, 8'h84, 8'h7f, 8'hff, 8'hff, 8'hff};
            default: bad = '{8'h04, 8'h83, 8'h01, 8'h00, 8'h00};
          endcase
          for (i = bad.size() - 1; i >= 0; i--) tlv_bytes.push_front(bad[i]);
          send_buffer(tlv_bytes.size(), tlv_bytes.size());
        end
        4: send_buffer(size, $urandom_range(0, size - 1));   // next begin mid-parse
        5: begin
          send_request(btlv_pkg::OP_BEGIN, 8'($urandom), $urandom);
          send_noise($urandom_range(1, 10));
        end
        6: begin
          send_request(btlv_pkg::OP_BEGIN, 8'($urandom), $urandom_range(0, 3));
          send_noise($urandom_range(1, 6));
        end
        default: begin
          send_noise($urandom_range(1, 3));
          send_buffer(size, size);
        end
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_wellformed(500);
    test_backpressure();
    test_full_rate(200);
    test_malformed(450);
    s_tvalid <= 1'b0;
    // drain; the watchdog bounds this wait
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
